>>> sv/fntp_pkg.sv
// ----------------------------------------------------------------------------
// fntp_pkg
// Types, character codes and digit decoding shared by the number word parser.
// ----------------------------------------------------------------------------
package fntp_pkg;

   localparam logic [7:0] CH_QUOTE  = 8'd39;
   localparam logic [7:0] CH_PCT    = 8'd37;
   localparam logic [7:0] CH_HASH   = 8'd35;
   localparam logic [7:0] CH_DOLLAR = 8'd36;
   localparam logic [7:0] CH_MINUS  = 8'd45;
   localparam logic [7:0] CASE_FOLD = 8'd32;

   localparam int unsigned BASE_BITS = 6;
   localparam logic [BASE_BITS-1:0] BASE_RESET = 6'd10;
   localparam logic [BASE_BITS-1:0] BASE_BIN   = 6'd2;
   localparam logic [BASE_BITS-1:0] BASE_DEC   = 6'd10;
   localparam logic [BASE_BITS-1:0] BASE_HEX   = 6'd16;

   localparam logic [2:0] PH_START  = 3'd0;
   localparam logic [2:0] PH_BIN    = 3'd1;
   localparam logic [2:0] PH_DEC    = 3'd2;
   localparam logic [2:0] PH_HEX    = 3'd3;
   localparam logic [2:0] PH_DIGITS = 3'd4;

   localparam logic [2:0] POS_SAT = 3'd7;

   typedef struct packed {
      logic [2:0]           char_position;
      logic [2:0]           prefix_phase;
      logic [BASE_BITS-1:0] active_base;
      logic                 negative_flag;
      logic                 failed_flag;
      logic [7:0]           literal_char;
      logic                 literal_candidate;
   } word_state_type;

   typedef struct packed {
      logic                 is_digit;
      logic [BASE_BITS-1:0] value;
   } digit_type;

   localparam word_state_type WORD_CLEAR = '{
      char_position:     3'd0,
      prefix_phase:      PH_START,
      active_base:       BASE_RESET,
      negative_flag:     1'b0,
      failed_flag:       1'b0,
      literal_char:      8'd0,
      literal_candidate: 1'b0
   };

   // Letters fold to upper case, so 'a'..'z' and 'A'..'Z' both give 10..35.
   function automatic digit_type digit_decode(input logic [7:0] c);
      digit_type  d;
      logic [7:0] u;
      d.is_digit = 1'b0;
      d.value    = '0;
      u = (c >= 8'd97 && c <= 8'd122) ? c - CASE_FOLD : c;
      if (c >= 8'd48 && c <= 8'd57) begin
         d.is_digit = 1'b1;
         d.value    = BASE_BITS'(c - 8'd48);
      end else if (u >= 8'd65 && u <= 8'd90) begin
         d.is_digit = 1'b1;
         d.value    = BASE_BITS'(u - 8'd55);
      end
      return d;
   endfunction

endpackage

>>> sv/fntp_req_if.sv
// ----------------------------------------------------------------------------
// fntp_req_if
// Character channel: one byte of a word per beat, with a flag on the last.
// ----------------------------------------------------------------------------
interface fntp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       last;

   modport source (output valid, output ch, output last, input ready);
   modport sink   (input valid, input ch, input last, output ready);
endinterface

>>> sv/fntp_rsp_if.sv
// ----------------------------------------------------------------------------
// fntp_rsp_if
// Result channel: one beat per word, a validity flag and the parsed value.
// ----------------------------------------------------------------------------
interface fntp_rsp_if;
   logic               valid;
   logic               ready;
   logic               valid_res;
   logic signed [31:0] value;

   modport source (output valid, output valid_res, output value, input ready);
   modport sink   (input valid, input valid_res, input value, output ready);
endinterface

>>> sv/fntp_csr_if.sv
// ----------------------------------------------------------------------------
// fntp_csr_if
// Register write channel carrying the default number base.
// ----------------------------------------------------------------------------
interface fntp_csr_if;
   logic       valid;
   logic       ready;
   logic [5:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> sv/fntp_step.sv
// ----------------------------------------------------------------------------
// fntp_step
// Next-state and result logic for one character of a number word.
// ----------------------------------------------------------------------------
module fntp_step #(
   parameter int unsigned CELL_BITS = 32
) (
   input  fntp_pkg::word_state_type   st,
   input  logic [CELL_BITS-1:0]       acc,
   input  logic [5:0]                 default_base,
   input  logic [7:0]                 ch,
   input  logic                       last,
   output fntp_pkg::word_state_type   st_next,
   output logic [CELL_BITS-1:0]       acc_next,
   output logic                       valid_res,
   output logic signed [31:0]         value
);
   import fntp_pkg::*;

   word_state_type               upd;
   logic [CELL_BITS-1:0]         acc_upd;
   logic [BASE_BITS-1:0]         base_cur;
   digit_type                    dig;
   logic [CELL_BITS-1:0]         product;
   logic signed [CELL_BITS-1:0]  num_cell;

   assign base_cur = (st.char_position == 3'd0) ? default_base : st.active_base;
   assign dig      = digit_decode(ch);
   assign product  = CELL_BITS'(acc * CELL_BITS'(base_cur));

   always_comb begin
      upd = st;
      acc_upd = acc;
      upd.active_base = base_cur;

      case (st.char_position)
         3'd0: upd.literal_candidate = (ch == CH_QUOTE);
         3'd1: upd.literal_char = ch;
         3'd2: upd.literal_candidate = st.literal_candidate && (ch == CH_QUOTE);
         default: upd.literal_candidate = 1'b0;
      endcase

      if (!st.failed_flag) begin
         if (st.prefix_phase == PH_START && ch == CH_PCT) begin
            upd.active_base  = BASE_BIN;
            upd.prefix_phase = PH_BIN;
         end else if (st.prefix_phase <= PH_BIN && ch == CH_HASH) begin
            upd.active_base  = BASE_DEC;
            upd.prefix_phase = PH_DEC;
         end else if (st.prefix_phase <= PH_DEC && ch == CH_DOLLAR) begin
            upd.active_base  = BASE_HEX;
            upd.prefix_phase = PH_HEX;
         end else if (st.prefix_phase < PH_DIGITS && ch == CH_MINUS
                      && base_cur == BASE_DEC) begin
            // A sign is only taken straight after the prefixes, in base ten.
            upd.prefix_phase  = PH_DIGITS;
            upd.negative_flag = 1'b1;
         end else begin
            upd.prefix_phase = PH_DIGITS;
            if (!dig.is_digit || dig.value >= base_cur) begin
               upd.failed_flag = 1'b1;
            end else begin
               acc_upd = product + CELL_BITS'(dig.value);
            end
         end
      end

      if (st.char_position != POS_SAT) begin
         upd.char_position = st.char_position + 3'd1;
      end
   end

   assign num_cell = upd.negative_flag ? -acc_upd : acc_upd;

   always_comb begin
      valid_res = 1'b0;
      value     = '0;
      if (st.char_position == 3'd2 && upd.literal_candidate) begin
         valid_res = 1'b1;
         value     = 32'(signed'(st.literal_char));
      end else if (!upd.failed_flag) begin
         valid_res = 1'b1;
         value     = 32'(num_cell);
      end
   end

   // The word ends on the last beat, so the next word starts from a clean state.
   always_comb begin
      if (last) begin
         st_next = WORD_CLEAR;
         st_next.active_base = default_base;
         acc_next = '0;
      end else begin
         st_next  = upd;
         acc_next = acc_upd;
      end
   end

endmodule

>>> sv/forth_number_token_parser_unit.sv
// ----------------------------------------------------------------------------
// forth_number_token_parser_unit
// Recognises a Forth number word from its characters and returns its value.
// ----------------------------------------------------------------------------
// Characters of one word arrive on req_bus, one byte per beat, with last set
// on the final byte. Every word gives exactly one beat on rsp_bus after its
// last character: valid_res says whether the word is a number, value holds
// the parsed cell (sign-extended or cut to 32 bits), or zero if not.
// csr_bus writes the default base; it is always ready and should only be
// written between words.
// One character is taken every cycle while req_ready is high. A beat is
// captured in the input register; from there the multiply-add by the base
// and the prefix checks update the word state and, on a last beat, load the
// result register. When the receiver stalls, the result is held and the
// character behind it in the input register waits only if it is itself a
// last beat; req_ready drops while that holds. Synchronous reset empties
// both registers, clears the word state and sets the default base to ten.
// ----------------------------------------------------------------------------
module forth_number_token_parser_unit #(
   parameter int unsigned CELL_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   fntp_req_if.sink    req_bus,
   fntp_rsp_if.source  rsp_bus,
   fntp_csr_if.sink    csr_bus
);
   import fntp_pkg::*;

   logic                       in_valid_ff, in_valid_in;
   logic [7:0]                 in_ch_ff;
   logic                       in_last_ff;
   word_state_type             st_ff, st_in;
   logic [CELL_BITS-1:0]       acc_ff, acc_in;
   logic [BASE_BITS-1:0]       default_base_ff;
   logic                       out_valid_ff, out_valid_in;
   logic                       out_valid_res_ff;
   logic signed [31:0]         out_value_ff;
   logic                       step_valid_res;
   logic signed [31:0]         step_value;
   logic                       proceed;
   logic                       req_take;

   // A character with no result never waits for the output side.
   assign proceed  = in_valid_ff && (!in_last_ff || !out_valid_ff || rsp_bus.ready);
   assign req_take = req_bus.valid && req_bus.ready;

   assign req_bus.ready = !in_valid_ff || proceed;
   assign csr_bus.ready = 1'b1;

   assign rsp_bus.valid     = out_valid_ff;
   assign rsp_bus.valid_res = out_valid_res_ff;
   assign rsp_bus.value     = out_value_ff;

   fntp_step #(
      .CELL_BITS (CELL_BITS)
   ) u_step (
      .st           (st_ff),
      .acc          (acc_ff),
      .default_base (default_base_ff),
      .ch           (in_ch_ff),
      .last         (in_last_ff),
      .st_next      (st_in),
      .acc_next     (acc_in),
      .valid_res    (step_valid_res),
      .value        (step_value)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_bus.ready) begin
         in_valid_in = req_bus.valid;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (proceed && in_last_ff) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         st_ff           <= WORD_CLEAR;
         acc_ff          <= '0;
         default_base_ff <= BASE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (proceed) begin
            st_ff  <= st_in;
            acc_ff <= acc_in;
         end
         if (csr_bus.valid) begin
            default_base_ff <= csr_bus.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ch_ff   <= req_bus.ch;
         in_last_ff <= req_bus.last;
      end
      if (proceed && in_last_ff) begin
         out_valid_res_ff <= step_valid_res;
         out_value_ff     <= step_value;
      end
   end

endmodule

>>> sv/fntp_checker.sv
// ----------------------------------------------------------------------------
// fntp_checker
// Port-level checks on the number word parser, bound to its top level.
// ----------------------------------------------------------------------------
module fntp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_last,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_valid_res,
   input logic [31:0] rsp_value
);

   // A result beat on offer stays on offer until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat withdrawn while stalled");

   // A word that is not a number always reports the value zero.
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |-> rsp_value == 32'd0)
      else $error("rejected word carries a non-zero value");

   // A fresh result must come from an accepted last character.
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_last, 2))
      else $error("result beat without a closing character");

   // Reset leaves no result on offer.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result beat present straight after reset");

endmodule

bind forth_number_token_parser_unit fntp_checker u_fntp_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .req_last      (req_bus.last),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_valid_res (rsp_bus.valid_res),
   .rsp_value     (rsp_bus.value)
);

>>> tb/forth_number_token_parser_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// forth_number_token_parser_unit_tb
// Self-checking bench for the number word parser.
// ----------------------------------------------------------------------------
// Words go in one character per beat. Each accepted beat also steps a
// behavioural parser kept in the bench, and every completed word queues the
// expected verdict and value. Result beats are checked in order against that
// queue. Directed words cover literals, prefixes, signs, rejected bytes and
// extreme bases; random words then run under several default bases and idling mixes.
// ----------------------------------------------------------------------------
module forth_number_token_parser_unit_tb;
   import fntp_pkg::*;

   localparam int unsigned RESET_CYCLES      = 6;
   localparam int unsigned DRAIN_CYCLES      = 8;
   localparam int unsigned CYCLE_LIMIT       = 200000;
   localparam int unsigned CHARS_PER_SEGMENT = 117;
   localparam int unsigned NOT_A_DIGIT       = 99;

   localparam logic [BASE_BITS-1:0] SWEEP_BASES [12] = '{
      6'd10, 6'd16, 6'd2, 6'd36,
      6'd0,  6'd1,  6'd37, 6'd63,
      6'd8,  6'd3,  6'd35, 6'd10
   };

   typedef struct packed {
      logic               valid_res;
      logic signed [31:0] value;
   } word_result_type;

   logic clock;
   logic reset;

   fntp_req_if req_bus ();
   fntp_rsp_if rsp_bus ();
   fntp_csr_if csr_bus ();

   forth_number_token_parser_unit DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Shadow of the parser's word state.
   logic [BASE_BITS-1:0] default_base_shadow;
   logic [2:0]           parse_pos;
   logic [2:0]           parse_phase;
   logic [BASE_BITS-1:0] parse_base;
   logic                 parse_neg;
   logic                 parse_fail;
   logic [31:0]          parse_acc;
   logic [7:0]           parse_lit_char;
   logic                 parse_lit_cand;

   word_result_type word_results_q [$];
   word_result_type expected_word;
   logic [7:0]      word_chars [$];

   int unsigned sender_idle_pct;
   int unsigned receiver_idle_pct;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      mismatch_count++;
   endtask

   function automatic int unsigned char_digit_value(input logic [7:0] c);
      logic [7:0] up;
      up = (c >= "a" && c <= "z") ? c - CASE_FOLD : c;
      if (c >= "0" && c <= "9") return c - "0";
      if (up >= "A" && up <= "Z") return up - "A" + 10;
      return NOT_A_DIGIT;
   endfunction

   task automatic clear_word_state();
      parse_pos      = 3'd0;
      parse_phase    = PH_START;
      parse_base     = default_base_shadow;
      parse_neg      = 1'b0;
      parse_fail     = 1'b0;
      parse_acc      = '0;
      parse_lit_char = '0;
      parse_lit_cand = 1'b0;
   endtask

   // Steps the shadow parser by one character and queues the verdict on the
   // last character of a word.
   task automatic parse_char(input logic [7:0] c, input logic is_last);
      logic [2:0]      pos;
      int unsigned     d;
      word_result_type r;
      pos = parse_pos;
      if (pos == 3'd0) begin
         parse_base     = default_base_shadow;
         parse_lit_cand = (c == CH_QUOTE);
      end else if (pos == 3'd1) begin
         parse_lit_char = c;
      end else if (pos == 3'd2) begin
         parse_lit_cand = parse_lit_cand && (c == CH_QUOTE);
      end else begin
         parse_lit_cand = 1'b0;
      end

      if (!parse_fail) begin
         if (parse_phase == PH_START && c == CH_PCT) begin
            parse_base  = BASE_BIN;
            parse_phase = PH_BIN;
         end else if (parse_phase <= PH_BIN && c == CH_HASH) begin
            parse_base  = BASE_DEC;
            parse_phase = PH_DEC;
         end else if (parse_phase <= PH_DEC && c == CH_DOLLAR) begin
            parse_base  = BASE_HEX;
            parse_phase = PH_HEX;
         end else if (parse_phase < PH_DIGITS && c == CH_MINUS
                      && parse_base == BASE_DEC) begin
            parse_phase = PH_DIGITS;
            parse_neg   = 1'b1;
         end else begin
            // A minus sign once digits have started is simply a bad digit.
            parse_phase = PH_DIGITS;
            d = char_digit_value(c);
            if (d >= parse_base) parse_fail = 1'b1;
            else parse_acc = parse_acc * 32'(parse_base) + 32'(d);
         end
      end
      if (parse_pos != POS_SAT) parse_pos++;

      if (is_last) begin
         if (pos == 3'd2 && parse_lit_cand) begin
            r.valid_res = 1'b1;
            r.value     = {{24{parse_lit_char[7]}}, parse_lit_char};
         end else if (parse_fail) begin
            r.valid_res = 1'b0;
            r.value     = '0;
         end else begin
            r.valid_res = 1'b1;
            r.value     = parse_neg ? -parse_acc : parse_acc;
         end
         word_results_q.push_back(r);
         clear_word_state();
      end
   endtask

   task automatic send_char(input logic [7:0] c, input logic is_last);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.ch    <= c;
      req_bus.last  <= is_last;
      do @(posedge clock); while (!req_bus.ready);
      parse_char(c, is_last);
   endtask

   task automatic send_word();
      foreach (word_chars[i]) send_char(word_chars[i], i == word_chars.size() - 1);
   endtask

   task automatic send_text(input string s);
      word_chars.delete();
      for (int i = 0; i < s.len(); i++) word_chars.push_back(s[i]);
      send_word();
   endtask

   // Lets every queued word come back, then waits on with no request so that the
   // block is truly quiet.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (word_results_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_default_base(input logic [BASE_BITS-1:0] b);
      drain_results();
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= b;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      default_base_shadow = b;
      parse_base          = b;
   endtask

   function automatic logic [7:0] digit_char(input int unsigned d);
      if (d < 10) return 8'("0" + d);
      return ($urandom_range(1) != 0) ? 8'("a" + d - 10) : 8'("A" + d - 10);
   endfunction

   // Bytes that tend to upset a parser: any byte, digits, punctuation around the
   // digit and letter ranges, prefix, sign and quote characters, high bytes.
   function automatic logic [7:0] noise_char();
      case ($urandom_range(5))
         0: return 8'($urandom_range(255));
         1: return 8'($urandom_range(64, 58));
         2: return 8'($urandom_range(96, 91));
         3: begin
            case ($urandom_range(4))
               0: return CH_PCT;
               1: return CH_HASH;
               2: return CH_DOLLAR;
               3: return CH_MINUS;
               default: return CH_QUOTE;
            endcase
         end
         4: return 8'($urandom_range(255, 123));
         default: return 8'($urandom_range(57, 48));
      endcase
   endfunction

   task automatic build_random_word();
      int unsigned          kind;
      int unsigned          n;
      int unsigned          top;
      logic [BASE_BITS-1:0] b;
      word_chars.delete();
      kind = $urandom_range(99);
      if (kind < 75) begin
         b = default_base_shadow;
         if ($urandom_range(9) < 4) begin
            word_chars.push_back(CH_PCT);
            b = BASE_BIN;
         end
         if ($urandom_range(9) < 3) begin
            word_chars.push_back(CH_HASH);
            b = BASE_DEC;
         end
         if ($urandom_range(9) < 4) begin
            word_chars.push_back(CH_DOLLAR);
            b = BASE_HEX;
         end
         if ((b == BASE_DEC) ? ($urandom_range(1) == 1) : ($urandom_range(19) == 0))
            word_chars.push_back(CH_MINUS);
         // Now and then a long digit string, so that the cell wraps.
         n   = ($urandom_range(9) == 0) ? $urandom_range(20, 9) : $urandom_range(6);
         top = (b == 0 || b > 36) ? 35 : b - 1;
         repeat (n) word_chars.push_back(digit_char($urandom_range(top)));
         if (word_chars.size() == 0) word_chars.push_back("0");
         if (kind >= 65) word_chars[$urandom_range(word_chars.size() - 1)] = noise_char();
      end else if (kind < 87) begin
         word_chars.push_back(CH_QUOTE);
         word_chars.push_back(8'($urandom_range(255)));
         case ($urandom_range(4))
            0: ;
            1: word_chars.push_back(noise_char());
            2: begin
               word_chars.push_back(CH_QUOTE);
               word_chars.push_back(CH_QUOTE);
            end
            default: word_chars.push_back(CH_QUOTE);
         endcase
      end else begin
         repeat ($urandom_range(9, 1)) word_chars.push_back(noise_char());
      end
   endtask

   task automatic test_char_literals();
      send_text("'A'");
      word_chars = '{CH_QUOTE, 8'hFF, CH_QUOTE};
      send_word();
   endtask

   task automatic test_prefix_and_sign();
      send_text("%#$");
      send_text("-");
      send_text("$-");
      send_text("$fF");
   endtask

   task automatic test_rejected_bytes();
      send_text(":");
      send_text("@");
      word_chars = '{8'h80};
      send_word();
      word_chars = '{8'h00};
      send_word();
   endtask

   task automatic test_base_extremes();
      write_default_base(6'd0);
      send_text("0");
      write_default_base(6'd1);
      send_text("0");
      send_text("1");
      write_default_base(6'd63);
      send_text("zZ");
   endtask

   task automatic test_random_words(input int unsigned first_base);
      int unsigned sent;
      for (int s = 0; s < 4; s++) begin
         write_default_base(SWEEP_BASES[first_base + s]);
         sent = 0;
         while (sent < CHARS_PER_SEGMENT) begin
            build_random_word();
            send_word();
            sent += word_chars.size();
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (word_results_q.size() == 0) begin
            report_mismatch("result beat with no word pending");
         end else begin
            expected_word = word_results_q.pop_front();
            if (rsp_bus.valid_res !== expected_word.valid_res)
               report_mismatch($sformatf("valid_res got %0b, want %0b",
                                         rsp_bus.valid_res, expected_word.valid_res));
            if (rsp_bus.value !== expected_word.value)
               report_mismatch($sformatf("value got %0d, want %0d",
                                         rsp_bus.value, expected_word.value));
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("forth_number_token_parser_unit_tb NOT OK");
         $finish;
      end
   end

   initial begin
      sender_idle_pct     = 34;
      receiver_idle_pct   = 74;
      default_base_shadow = BASE_RESET;
      clear_word_state();
      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.ch    <= '0;
      req_bus.last  <= 1'b0;
      csr_bus.valid <= 1'b0;
      csr_bus.data  <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_char_literals();
      test_prefix_and_sign();
      test_rejected_bytes();
      test_base_extremes();

      test_random_words(0);
      sender_idle_pct   = 74;
      receiver_idle_pct = 34;
      test_random_words(4);
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      test_random_words(8);

      drain_results();
      if (mismatch_count == 0) begin
         $display("forth_number_token_parser_unit_tb OK");
      end else begin
         $display("forth_number_token_parser_unit_tb NOT OK");
      end
      $finish;
   end

endmodule

>>> sim.f
sv/fntp_pkg.sv
sv/fntp_req_if.sv
sv/fntp_rsp_if.sv
sv/fntp_csr_if.sv
sv/fntp_step.sv
sv/forth_number_token_parser_unit.sv
sv/fntp_checker.sv
tb/forth_number_token_parser_unit_tb.sv
